// File: hw/rtl/assert_macros.svh
// Assertion macros used by accumulator_cpu_step.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define ACPU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define ACPU_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: hw/rtl/acpu_pkg.sv
package acpu_pkg;

  // Field widths
  localparam int unsigned WordW   = 16;
  localparam int unsigned OpW     = 2;
  localparam int unsigned StatusW = 3;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 2;

  // Input word operations
  typedef enum logic [OpW-1:0] {
    OP_EXEC  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    STAT_OK       = 3'd0,
    STAT_BAD_OPC  = 3'd1,
    STAT_DIV_ZERO = 3'd2,
    STAT_DEV_RD   = 3'd3,
    STAT_DEV_WR   = 3'd4
  } status_e;

  // Instruction opcodes
  localparam logic [ByteW-1:0] OPC_ADD    = 8'h01;
  localparam logic [ByteW-1:0] OPC_SUB    = 8'h02;
  localparam logic [ByteW-1:0] OPC_LOAD   = 8'h03;
  localparam logic [ByteW-1:0] OPC_STORE  = 8'h04;
  localparam logic [ByteW-1:0] OPC_MUL    = 8'h05;
  localparam logic [ByteW-1:0] OPC_DIV    = 8'h06;
  localparam logic [ByteW-1:0] OPC_PUSH   = 8'h07;
  localparam logic [ByteW-1:0] OPC_POP    = 8'h08;
  localparam logic [ByteW-1:0] OPC_DEV_RD = 8'h09;
  localparam logic [ByteW-1:0] OPC_DEV_WR = 8'h0A;
  localparam logic [ByteW-1:0] OPC_AND    = 8'h0B;
  localparam logic [ByteW-1:0] OPC_OR     = 8'h0C;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_DEV_BLOCK  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DEV_BUFFER = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DEV_SIZE   = 2'd2;

  // Reset value of the stack pointer
  localparam logic [WordW-1:0] SP_RESET = 16'hFFFF;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_RDATA,
    S_DECODE,
    S_MEMRD,
    S_DIV,
    S_RESP
  } state_e;

endpackage

// File: hw/rtl/acpu_if.sv
// Input word channel: one operation per word.
interface acpu_in_if;
  logic                                valid;
  logic                                ready;
  logic [acpu_pkg::OpW-1:0]            op;
  logic [acpu_pkg::WordW-1:0]          addr;
  logic [acpu_pkg::WordW-1:0]          wdata;

  modport source (output valid, op, addr, wdata, input ready);
  modport sink   (input valid, op, addr, wdata, output ready);
endinterface

// Result word channel: one result per input word.
interface acpu_out_if;
  logic                                valid;
  logic                                ready;
  logic [acpu_pkg::StatusW-1:0]        status;
  logic [acpu_pkg::WordW-1:0]          acc_value;
  logic [acpu_pkg::WordW-1:0]          pc_value;
  logic [acpu_pkg::WordW-1:0]          read_word;
  logic [acpu_pkg::ByteW-1:0]          dev_slot;
  logic [acpu_pkg::WordW-1:0]          dev_block;
  logic [acpu_pkg::WordW-1:0]          dev_buffer;
  logic [acpu_pkg::WordW-1:0]          dev_size;

  modport source (output valid, status, acc_value, pc_value, read_word,
                  dev_slot, dev_block, dev_buffer, dev_size, input ready);
  modport sink   (input valid, status, acc_value, pc_value, read_word,
                  dev_slot, dev_block, dev_buffer, dev_size, output ready);
endinterface

// Configuration write channel.
interface acpu_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [acpu_pkg::CfgIdxW-1:0]        index;
  logic [acpu_pkg::WordW-1:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/accumulator_cpu_step.sv
// Accept to result valid: a write or unused op goes idle, response; a read goes idle,
// read data, response; an instruction goes idle (fetch), decode, then a memory read
// for load and pop or divide steps (one quotient bit per cycle) for a nonzero divisor,
// then response. A new word is taken only in idle, once the last result is registered.
// Reset (async, active low): accumulator and pc to zero, sp to 0xFFFF, device
// registers to zero; the word memory is not cleared and holds garbage until written.
`include "assert_macros.svh"

module accumulator_cpu_step #(
  parameter int unsigned MEM_DEPTH = 65536
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  acpu_in_if.sink      in_i,
  acpu_out_if.source   out_o,
  acpu_cfg_if.sink     cfg_i
);

  localparam int unsigned AW = $clog2(MEM_DEPTH);
  localparam int unsigned WW = acpu_pkg::WordW;
  localparam int unsigned BW = acpu_pkg::ByteW;
  localparam logic [3:0]  DIV_LAST = 4'd15;

  // Word memory
  logic [WW-1:0] mem_q [MEM_DEPTH];
  logic [WW-1:0] rdata_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [WW-1:0] mem_wdata;

  // Architectural state and configuration
  logic [WW-1:0] acc_q, acc_d;
  logic [WW-1:0] pc_q, pc_d;
  logic [WW-1:0] sp_q, sp_d;
  logic [WW-1:0] dev_block_q, dev_buffer_q, dev_size_q;

  // Sequencer and per-word scratch
  acpu_pkg::state_e  state_q, state_d;
  acpu_pkg::status_e res_status_q, res_status_d;
  logic [WW-1:0]     res_rword_q, res_rword_d;
  logic [WW-1:0]     ir_q, ir_d;

  // Divider
  logic [WW-1:0] dq_q, dq_d;
  logic [BW-1:0] rem_q, rem_d;
  logic [3:0]    div_cnt_q, div_cnt_d;
  logic [BW:0]   div_trial;
  logic          div_ge;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic [2:0]        out_status_q, out_status_d;
  logic [WW-1:0]     out_acc_q, out_acc_d;
  logic [WW-1:0]     out_pc_q, out_pc_d;
  logic [WW-1:0]     out_rword_q, out_rword_d;
  logic [BW-1:0]     out_slot_q, out_slot_d;
  logic [WW-1:0]     out_block_q, out_block_d;
  logic [WW-1:0]     out_buffer_q, out_buffer_d;
  logic [WW-1:0]     out_size_q, out_size_d;

  logic          in_fire, cfg_fire, out_free, dev_req;
  logic [BW-1:0] opc, opnd;
  logic [AW-1:0] opnd_addr;
  logic [WW-1:0] sp_inc;

  assign in_i.ready  = (state_q == acpu_pkg::S_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;

  // Fetched word splits into opcode and operand
  assign opc       = rdata_q[WW-1:BW];
  assign opnd      = rdata_q[BW-1:0];
  assign opnd_addr = AW'(opnd);
  assign sp_inc    = sp_q + 16'd1;

  // One restoring divide step on the stored divisor
  assign div_trial = {rem_q, dq_q[WW-1]};
  assign div_ge    = (div_trial >= {1'b0, ir_q[BW-1:0]});

  assign dev_req = (res_status_q == acpu_pkg::STAT_DEV_RD) ||
                   (res_status_q == acpu_pkg::STAT_DEV_WR);

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      acpu_pkg::S_IDLE: begin
        if (in_fire) begin
          unique case (in_i.op)
            acpu_pkg::OP_EXEC: state_d = acpu_pkg::S_DECODE;
            acpu_pkg::OP_READ: state_d = acpu_pkg::S_RDATA;
            default:           state_d = acpu_pkg::S_RESP;
          endcase
        end
      end
      acpu_pkg::S_RDATA: state_d = acpu_pkg::S_RESP;
      acpu_pkg::S_DECODE: begin
        unique case (opc)
          acpu_pkg::OPC_LOAD, acpu_pkg::OPC_POP: state_d = acpu_pkg::S_MEMRD;
          acpu_pkg::OPC_DIV:
            state_d = (opnd != '0) ? acpu_pkg::S_DIV : acpu_pkg::S_RESP;
          default: state_d = acpu_pkg::S_RESP;
        endcase
      end
      acpu_pkg::S_MEMRD: state_d = acpu_pkg::S_RESP;
      acpu_pkg::S_DIV: begin
        if (div_cnt_q == DIV_LAST) state_d = acpu_pkg::S_RESP;
      end
      acpu_pkg::S_RESP: begin
        if (out_free) state_d = acpu_pkg::S_IDLE;
      end
      default: state_d = acpu_pkg::S_IDLE;
    endcase
  end

  // Sequencer datapath and memory control
  always_comb begin
    acc_d        = acc_q;
    pc_d         = pc_q;
    sp_d         = sp_q;
    ir_d         = ir_q;
    res_status_d = res_status_q;
    res_rword_d  = res_rword_q;
    dq_d         = dq_q;
    rem_d        = rem_q;
    div_cnt_d    = div_cnt_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = '0;
    mem_raddr    = '0;
    mem_wdata    = '0;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_acc_d    = out_acc_q;
    out_pc_d     = out_pc_q;
    out_rword_d  = out_rword_q;
    out_slot_d   = out_slot_q;
    out_block_d  = out_block_q;
    out_buffer_d = out_buffer_q;
    out_size_d   = out_size_q;

    // Drop the result once taken
    if (out_o.ready) out_valid_d = 1'b0;

    unique case (state_q)
      acpu_pkg::S_IDLE: begin
        if (in_fire) begin
          res_status_d = acpu_pkg::STAT_OK;
          res_rword_d  = '0;
          mem_re       = 1'b1;
          mem_raddr    = (in_i.op == acpu_pkg::OP_EXEC) ? pc_q[AW-1:0] : in_i.addr[AW-1:0];
          if (in_i.op == acpu_pkg::OP_WRITE) begin
            mem_we    = 1'b1;
            mem_waddr = in_i.addr[AW-1:0];
            mem_wdata = in_i.wdata;
          end
        end
      end
      acpu_pkg::S_RDATA: res_rword_d = rdata_q;
      acpu_pkg::S_DECODE: begin
        ir_d = rdata_q;
        pc_d = pc_q + 16'd1;
        unique case (opc)
          acpu_pkg::OPC_ADD: acc_d = acc_q + WW'(opnd);
          acpu_pkg::OPC_SUB: acc_d = acc_q - WW'(opnd);
          acpu_pkg::OPC_LOAD: begin
            mem_re    = 1'b1;
            mem_raddr = opnd_addr;
          end
          acpu_pkg::OPC_STORE: begin
            mem_we    = 1'b1;
            mem_waddr = opnd_addr;
            mem_wdata = acc_q;
          end
          acpu_pkg::OPC_MUL: acc_d = WW'(acc_q * WW'(opnd));
          acpu_pkg::OPC_DIV: begin
            if (opnd == '0) begin
              res_status_d = acpu_pkg::STAT_DIV_ZERO;
            end else begin
              dq_d      = acc_q;
              rem_d     = '0;
              div_cnt_d = '0;
            end
          end
          acpu_pkg::OPC_PUSH: begin
            mem_we    = 1'b1;
            mem_waddr = sp_q[AW-1:0];
            mem_wdata = acc_q;
            sp_d      = sp_q - 16'd1;
          end
          acpu_pkg::OPC_POP: begin
            sp_d      = sp_inc;
            mem_re    = 1'b1;
            mem_raddr = sp_inc[AW-1:0];
          end
          acpu_pkg::OPC_DEV_RD: res_status_d = acpu_pkg::STAT_DEV_RD;
          acpu_pkg::OPC_DEV_WR: res_status_d = acpu_pkg::STAT_DEV_WR;
          acpu_pkg::OPC_AND: acc_d = acc_q & WW'(opnd);
          acpu_pkg::OPC_OR:  acc_d = acc_q | WW'(opnd);
          default: res_status_d = acpu_pkg::STAT_BAD_OPC;
        endcase
      end
      acpu_pkg::S_MEMRD: acc_d = rdata_q;
      acpu_pkg::S_DIV: begin
        rem_d     = div_ge ? BW'(div_trial - {1'b0, ir_q[BW-1:0]}) : div_trial[BW-1:0];
        dq_d      = {dq_q[WW-2:0], div_ge};
        div_cnt_d = div_cnt_q + 4'd1;
        if (div_cnt_q == DIV_LAST) acc_d = {dq_q[WW-2:0], div_ge};
      end
      acpu_pkg::S_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_acc_d    = acc_q;
          out_pc_d     = pc_q;
          out_rword_d  = res_rword_q;
          out_slot_d   = dev_req ? ir_q[BW-1:0] : '0;
          out_block_d  = dev_req ? dev_block_q  : '0;
          out_buffer_d = dev_req ? dev_buffer_q : '0;
          out_size_d   = dev_req ? dev_size_q   : '0;
        end
      end
      default: ;
    endcase
  end

  // Word memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem_q[mem_raddr];
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= acpu_pkg::S_IDLE;
      acc_q       <= '0;
      pc_q        <= '0;
      sp_q        <= acpu_pkg::SP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      pc_q        <= pc_d;
      sp_q        <= sp_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Device registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_block_q  <= '0;
      dev_buffer_q <= '0;
      dev_size_q   <= '0;
    end else if (cfg_fire) begin
      unique case (cfg_i.index)
        acpu_pkg::CFG_DEV_BLOCK:  dev_block_q  <= cfg_i.data;
        acpu_pkg::CFG_DEV_BUFFER: dev_buffer_q <= cfg_i.data;
        acpu_pkg::CFG_DEV_SIZE:   dev_size_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ir_q         <= ir_d;
    res_status_q <= res_status_d;
    res_rword_q  <= res_rword_d;
    dq_q         <= dq_d;
    rem_q        <= rem_d;
    div_cnt_q    <= div_cnt_d;
    out_status_q <= out_status_d;
    out_acc_q    <= out_acc_d;
    out_pc_q     <= out_pc_d;
    out_rword_q  <= out_rword_d;
    out_slot_q   <= out_slot_d;
    out_block_q  <= out_block_d;
    out_buffer_q <= out_buffer_d;
    out_size_q   <= out_size_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.acc_value  = out_acc_q;
  assign out_o.pc_value   = out_pc_q;
  assign out_o.read_word  = out_rword_q;
  assign out_o.dev_slot   = out_slot_q;
  assign out_o.dev_block  = out_block_q;
  assign out_o.dev_buffer = out_buffer_q;
  assign out_o.dev_size   = out_size_q;

  // Checks
  `ACPU_ASSERT_RST(a_reset_idle, !rst_ni |=> state_q == acpu_pkg::S_IDLE && !out_valid_q, "reset leaves sequencer busy or result valid")
  `ACPU_ASSERT(a_accept_busy, in_fire |=> state_q != acpu_pkg::S_IDLE, "accepted word did not start the sequencer")
  `ACPU_ASSERT(a_result_from_resp, out_valid_q && !$past(out_valid_q) |-> $past(state_q == acpu_pkg::S_RESP), "result raised outside the response state")
  `ACPU_ASSERT(a_pc_step, pc_q != $past(pc_q) |-> pc_q == $past(pc_q) + 16'd1 && $past(state_q == acpu_pkg::S_DECODE), "pc moved by other than one instruction")
  `ACPU_ASSERT(a_sp_decode, sp_q != $past(sp_q) |-> $past(state_q == acpu_pkg::S_DECODE), "sp moved outside decode")
  `ACPU_ASSERT(a_mem_we_state, mem_we |-> state_q == acpu_pkg::S_IDLE || state_q == acpu_pkg::S_DECODE, "memory written in a read-only state")

endmodule
